// File: hdl/u8n_pkg.sv
// Shared types and constants for the UTF-8 shortest-form normalizer.
// Used by u8n_decode and utf8_overlong_normalizer; no dependencies.
package u8n_pkg;

    // Most results one source byte can release: six sequence bytes plus the terminator
    localparam int MAX_BURST = 7;
    localparam int CODE_W    = 31;

    // Emit queue depth: a power of two (pointers wrap), at least 8 and MAX_BURST + 1
    localparam int FIFO_DEPTH = 16;

    // Continuation byte is 10xxxxxx
    localparam logic [1:0] CONT_TAG = 2'b10;

    // One result item as it sits in the emit queue
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       chg;
    } result_t;

    // Results released by one accepted source byte, item 0 goes out first
    typedef struct packed {
        result_t [MAX_BURST-1:0] item;
        logic [2:0]              count;
    } burst_t;

    // Lead byte marker for an encoding with k continuation bytes
    function automatic logic [7:0] lead_prefix(input logic [2:0] k);
        logic [7:0] p;
        unique case (k)
            3'd0:    p = 8'h00;
            3'd1:    p = 8'hc0;
            3'd2:    p = 8'he0;
            3'd3:    p = 8'hf0;
            3'd4:    p = 8'hf8;
            3'd5:    p = 8'hfc;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

// File: hdl/utf8_overlong_normalizer.sv
// UTF-8 shortest-form normalizer, top level: stream ports and emit queue.
// Depends on u8n_pkg and u8n_decode.
//
// Usage:
//   Slave channel s_*: one source byte per transfer in s_tdata; a 0 byte ends
//   the string. Master channel m_*: one normalized byte per transfer; the
//   terminator comes with m_tdata = 0, m_tlast = 1 and m_tuser = changed
//   (1 if any sequence of the string was dropped or shortened).
//   A sequence is closed by the next non-continuation byte, so its bytes
//   appear only after that byte is taken. Results of a closing byte enter a
//   FIFO_DEPTH-entry emit queue at its transfer edge; m_tvalid rises on the
//   following cycle.
//   Throughput: one byte per cycle on both sides; s_tready is high while the
//   queue has room for the largest burst (seven results), which the output
//   side's one-byte-per-cycle drain keeps true in steady streaming.
//   Receiver stall: the queue holds results; s_tready drops once the queue
//   is too full for another burst and nothing is lost.
//   Reset (aresetn low, synchronous): queue emptied, no sequence open, flag
//   cleared.
module utf8_overlong_normalizer import u8n_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic       m_tuser    // [0] changed
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    result_t           fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wr_offset [FIFO_DEPTH];

    logic   in_accept;
    logic   pop;
    burst_t burst;

    assign s_tready  = count_reg <= CNT_W'(FIFO_DEPTH - MAX_BURST);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = count_reg != '0;
    assign pop       = m_tvalid && m_tready;

    u8n_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .burst     (burst)
    );

    // Queue pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(burst.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(burst.count) - CNT_W'(pop);
        for (int e = 0; e < FIFO_DEPTH; e++) begin
            wr_offset[e] = PTR_W'(e) - wr_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Burst write: each entry takes the burst item that lands on it
    always_ff @(posedge aclk) begin
        for (int e = 0; e < FIFO_DEPTH; e++) begin
            if (wr_offset[e] < PTR_W'(burst.count)) begin
                fifo_reg[e] <= burst.item[wr_offset[e][2:0]];
            end
        end
    end

    assign m_tdata = fifo_reg[rd_ptr_reg].data;
    assign m_tlast = fifo_reg[rd_ptr_reg].eos;
    assign m_tuser = fifo_reg[rd_ptr_reg].chg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("emit queue overfilled");

    a_chg_on_term_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !m_tuser)
        else $error("changed flag on a data byte");

    a_term_is_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == 8'h00)
        else $error("terminator carries a nonzero byte");

endmodule

// File: hdl/u8n_decode.sv
// Sequence tracker and shortest-form encoder for the UTF-8 normalizer.
// Holds the open-sequence state; produces the burst of results per byte.
// Depends on u8n_pkg.
module u8n_decode import u8n_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    output burst_t     burst
);

    logic              pending_reg, pending_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [2:0]        need_reg, need_next;
    logic              bad_reg, bad_next;
    logic              changed_reg, changed_next;
    logic [2:0]        len_reg, len_next;

    logic [35:0] code_ext;
    logic [2:0]  enc_len;
    logic        close_ok;
    logic        chg;
    logic [2:0]  n_close;
    logic [2:0]  dig;

    assign code_ext = {5'b0, code_reg};
    assign close_ok = pending_reg && !bad_reg && (need_reg == 3'd0);

    // Shortest encoding length from the highest set code point bit
    always_comb begin
        priority if (|code_reg[30:26]) enc_len = 3'd5;
        else if (|code_reg[25:21])     enc_len = 3'd4;
        else if (|code_reg[20:16])     enc_len = 3'd3;
        else if (|code_reg[15:11])     enc_len = 3'd2;
        else if (|code_reg[10:7])      enc_len = 3'd1;
        else                           enc_len = 3'd0;
    end

    // Next state and released results
    always_comb begin
        pending_next = pending_reg;
        code_next    = code_reg;
        need_next    = need_reg;
        bad_next     = bad_reg;
        changed_next = changed_reg;
        len_next     = len_reg;
        burst        = '0;
        chg          = changed_reg;
        n_close      = 3'd0;
        dig          = 3'd0;

        if (in_accept) begin
            if (pending_reg && (in_byte[7:6] == CONT_TAG)) begin
                // continuation: extend the open sequence
                if (need_reg == 3'd0) begin
                    bad_next = 1'b1;
                end else begin
                    need_next = need_reg - 3'd1;
                end
                code_next = {code_reg[CODE_W-7:0], in_byte[5:0]};
            end else begin
                // close the open sequence
                if (pending_reg) begin
                    if (!close_ok) begin
                        chg = 1'b1;
                    end else begin
                        if (enc_len < len_reg) chg = 1'b1;
                        for (int i = 0; i < MAX_BURST - 1; i++) begin
                            if (3'(i) <= enc_len) begin
                                dig = enc_len - 3'(i);
                                if (i == 0) begin
                                    if (enc_len == 3'd0) begin
                                        burst.item[i].data = {1'b0, code_reg[6:0]};
                                    end else begin
                                        burst.item[i].data = lead_prefix(enc_len) |
                                            {2'b00, code_ext[6*dig +: 6]};
                                    end
                                end else begin
                                    burst.item[i].data = {CONT_TAG, code_ext[6*dig +: 6]};
                                end
                            end
                        end
                        n_close = enc_len + 3'd1;
                    end
                end

                if (in_byte == 8'h00) begin
                    // terminator right after the closed sequence, then back to reset state
                    for (int i = 0; i < MAX_BURST; i++) begin
                        if (3'(i) == n_close) begin
                            burst.item[i].data = 8'h00;
                            burst.item[i].eos  = 1'b1;
                            burst.item[i].chg  = chg;
                        end
                    end
                    burst.count  = n_close + 3'd1;
                    pending_next = 1'b0;
                    code_next    = '0;
                    need_next    = 3'd0;
                    bad_next     = 1'b0;
                    changed_next = 1'b0;
                    len_next     = 3'd0;
                end else begin
                    burst.count  = n_close;
                    changed_next = chg;
                    pending_next = 1'b1;
                    bad_next     = 1'b0;
                    // open a new sequence from the lead byte
                    priority if (in_byte[7:1] == 7'b1111110) begin
                        need_next = 3'd5;
                        code_next = CODE_W'(in_byte[0]);
                    end else if (in_byte[7:2] == 6'b111110) begin
                        need_next = 3'd4;
                        code_next = CODE_W'(in_byte[1:0]);
                    end else if (in_byte[7:3] == 5'b11110) begin
                        need_next = 3'd3;
                        code_next = CODE_W'(in_byte[2:0]);
                    end else if (in_byte[7:4] == 4'b1110) begin
                        need_next = 3'd2;
                        code_next = CODE_W'(in_byte[3:0]);
                    end else if (in_byte[7:5] == 3'b110) begin
                        need_next = 3'd1;
                        code_next = CODE_W'(in_byte[4:0]);
                    end else if (in_byte[7] == 1'b0) begin
                        need_next = 3'd0;
                        code_next = CODE_W'(in_byte[6:0]);
                    end else begin
                        // stray continuation, 0xfe or 0xff
                        need_next = 3'd0;
                        code_next = '0;
                        bad_next  = 1'b1;
                    end
                    len_next = need_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            code_reg    <= '0;
            need_reg    <= 3'd0;
            bad_reg     <= 1'b0;
            changed_reg <= 1'b0;
            len_reg     <= 3'd0;
        end else begin
            pending_reg <= pending_next;
            code_reg    <= code_next;
            need_reg    <= need_next;
            bad_reg     <= bad_next;
            changed_reg <= changed_next;
            len_reg     <= len_next;
        end
    end

    // results only ever come from an accepted byte
    a_burst_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        burst.count != 3'd0 |-> in_accept)
        else $error("results released without an accepted byte");

    // a NUL byte leaves the tracker in its reset state
    a_nul_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && in_byte == 8'h00 |=> !pending_reg && !changed_reg && !bad_reg)
        else $error("state not cleared after terminator");

endmodule
